### sv/dsmt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package dsmt_pkg;

	localparam int CHAN_COUNT   = 8;
	localparam int LANES        = 8;
	localparam int FRAME_BITS   = 16;
	localparam int BIT_W        = $clog2(FRAME_BITS);
	localparam int TICK_W       = 16;
	localparam int THR_W        = 16;
	localparam int CH_W         = 3;
	localparam int CFG_IDX_W    = 3;
	localparam int CFG_DATA_W   = 16;
	localparam int VAL_W        = 11;

	localparam logic [VAL_W-1:0] MAX_VALUE = 11'd2047;

	typedef enum logic [1:0] {
		OP_WRITE = 2'd0,
		OP_SEND  = 2'd1,
		OP_TICK  = 2'd2
	} opcode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ACTIVE_MASK = 3'd0,
		REG_DSHOT_MASK  = 3'd1,
		REG_ZERO_HIGH   = 3'd2,
		REG_ONE_HIGH    = 3'd3,
		REG_BIT_PERIOD  = 3'd4
	} cfg_reg_t;

	// Per-lane control for the step being retired, with the timer state after it.
	typedef struct packed {
		logic              wr;
		logic              load;
		logic              in_frame;
		logic [BIT_W-1:0]  bit_n;
		logic [TICK_W-1:0] tick_n;
	} lane_ctl_t;

	// Saturate, shift past the telemetry bit and append the nibble checksum.
	function automatic logic [FRAME_BITS-1:0] make_frame(input logic [THR_W-1:0] value);
		logic [VAL_W-1:0]      v;
		logic [FRAME_BITS-1:0] p;
		logic [3:0]            crc;
		v   = (value > THR_W'(MAX_VALUE)) ? MAX_VALUE : value[VAL_W-1:0];
		p   = {v, 5'b0};
		crc = p[7:4] ^ p[11:8] ^ p[15:12];
		return {p[15:4], crc};
	endfunction

endpackage
`default_nettype wire

### sv/dsmt_cmd_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface dsmt_cmd_if;
	logic                        valid;
	logic                        ready;
	logic [1:0]                  opcode;
	logic [dsmt_pkg::CH_W-1:0]   channel;
	logic [dsmt_pkg::THR_W-1:0]  throttle;

	modport source (output valid, output opcode, output channel, output throttle, input ready);
	modport sink   (input valid, input opcode, input channel, input throttle, output ready);
endinterface
`default_nettype wire

### sv/dsmt_res_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface dsmt_res_if;
	logic                        valid;
	logic                        ready;
	logic [dsmt_pkg::LANES-1:0]  pin_levels;
	logic                        busy_res;

	modport source (output valid, output pin_levels, output busy_res, input ready);
	modport sink   (input valid, input pin_levels, input busy_res, output ready);
endinterface
`default_nettype wire

### sv/dsmt_cfg_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface dsmt_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [dsmt_pkg::CFG_IDX_W-1:0]   index;
	logic [dsmt_pkg::CFG_DATA_W-1:0]  wdata;

	modport source (output valid, output index, output wdata, input ready);
	modport sink   (input valid, input index, input wdata, output ready);
endinterface
`default_nettype wire

### sv/dsmt_lane.sv
`timescale 1ns / 1ps
`default_nettype none
module dsmt_lane (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire  dsmt_pkg::lane_ctl_t      ctl,
	input  wire  [dsmt_pkg::THR_W-1:0]     throttle,
	input  wire  [dsmt_pkg::TICK_W-1:0]    zero_high,
	input  wire  [dsmt_pkg::TICK_W-1:0]    one_high,
	output logic                           level
);
	import dsmt_pkg::*;

	logic [THR_W-1:0]      value_q;
	logic [FRAME_BITS-1:0] frame_q;
	logic [FRAME_BITS-1:0] frame_d;
	logic                  cur_bit;
	logic [TICK_W-1:0]     high;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			value_q <= '0;
		end else if (ctl.wr) begin
			value_q <= throttle;
		end else if (ctl.load) begin
			value_q <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			frame_q <= make_frame(value_q);
		end
	end

	// The level shown reflects the state after this step, so look at the new frame.
	always_comb begin
		frame_d = ctl.load ? make_frame(value_q) : frame_q;
		cur_bit = frame_d[BIT_W'(FRAME_BITS - 1) - ctl.bit_n];
		high    = cur_bit ? one_high : zero_high;
		level   = ctl.in_frame && (ctl.tick_n < high);
	end

endmodule
`default_nettype wire

### sv/dshot_multichannel_transmitter.sv
`timescale 1ns / 1ps
`default_nettype none
// Port  Role                Fields
// cmd   item in (sink)      opcode, channel, throttle
// res   result out (source) pin_levels, busy_res
// cfg   register write      index, wdata
//
// One command is taken every clock cycle while res is not stalled; each gives one
// result, registered in the command register and then in the result register.
// The result register only stalls the command register when it holds an
// untaken result, so a stall on res reaches cmd.ready in the same cycle.
// Reset clears the stored throttle values and the timer, and returns the
// registers to their defaults.
// Register writes are always taken in the cycle they are offered.
module dshot_multichannel_transmitter (
	input  wire         clk,
	input  wire         arst_n,
	dsmt_cmd_if.sink    cmd,
	dsmt_res_if.source  res,
	dsmt_cfg_if.sink    cfg
);
	import dsmt_pkg::*;

	localparam logic [LANES-1:0] LANE_EXISTS = LANES'((1 << CHAN_COUNT) - 1);

	// configuration
	logic [LANES-1:0]  active_mask_q;
	logic [LANES-1:0]  dshot_mask_q;
	logic [TICK_W-1:0] zero_high_q;
	logic [TICK_W-1:0] one_high_q;
	logic [TICK_W-1:0] period_q;

	// command stage
	logic              valid_s1;
	logic [1:0]        opcode_s1;
	logic [CH_W-1:0]   channel_s1;
	logic [THR_W-1:0]  throttle_s1;

	// transmit state
	logic              sending_q;
	logic [LANES-1:0]  mask_q;
	logic [BIT_W-1:0]  bit_q;
	logic [TICK_W-1:0] tick_q;

	logic              sending_n;
	logic [LANES-1:0]  mask_n;
	logic [BIT_W-1:0]  bit_n;
	logic [TICK_W-1:0] tick_n;

	logic              adv;
	logic              start;
	logic [LANES-1:0]  elig;
	logic [TICK_W-1:0] period_eff;
	logic [TICK_W:0]   tick_inc;
	logic [TICK_W-1:0] zero_eff;
	lane_ctl_t         ctl [LANES];
	logic [LANES-1:0]  levels;

	logic              res_valid_q;
	logic [LANES-1:0]  pin_levels_q;
	logic              busy_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_mask_q <= '0;
			dshot_mask_q  <= '0;
			zero_high_q   <= TICK_W'(125);
			one_high_q    <= TICK_W'(250);
			period_q      <= TICK_W'(333);
		end else if (cfg.valid) begin
			unique case (cfg_reg_t'(cfg.index))
				REG_ACTIVE_MASK: active_mask_q <= cfg.wdata[LANES-1:0];
				REG_DSHOT_MASK:  dshot_mask_q  <= cfg.wdata[LANES-1:0];
				REG_ZERO_HIGH:   zero_high_q   <= cfg.wdata[TICK_W-1:0];
				REG_ONE_HIGH:    one_high_q    <= cfg.wdata[TICK_W-1:0];
				REG_BIT_PERIOD:  period_q      <= cfg.wdata[TICK_W-1:0];
				default: ;
			endcase
		end
	end

	assign adv       = valid_s1 && (!res_valid_q || res.ready);
	assign cmd.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ready && cmd.valid) begin
			opcode_s1   <= cmd.opcode;
			channel_s1  <= cmd.channel;
			throttle_s1 <= cmd.throttle;
		end
	end

	assign elig       = active_mask_q & dshot_mask_q & LANE_EXISTS;
	assign period_eff = (period_q == '0) ? TICK_W'(1) : period_q;
	assign tick_inc   = {1'b0, tick_q} + (TICK_W+1)'(1);
	// A zero bit never stays high longer than a one bit.
	assign zero_eff   = (zero_high_q < one_high_q) ? zero_high_q : one_high_q;

	always_comb begin
		sending_n = sending_q;
		mask_n    = mask_q;
		bit_n     = bit_q;
		tick_n    = tick_q;
		start     = 1'b0;
		unique case (opcode_t'(opcode_s1))
			OP_SEND: begin
				if (!sending_q && elig != '0) begin
					start     = 1'b1;
					sending_n = 1'b1;
					mask_n    = elig;
					bit_n     = '0;
					tick_n    = '0;
				end
			end
			OP_TICK: begin
				if (sending_q) begin
					if (tick_inc >= {1'b0, period_eff}) begin
						tick_n = '0;
						if (bit_q == BIT_W'(FRAME_BITS - 1)) begin
							bit_n     = '0;
							sending_n = 1'b0;
							mask_n    = '0;
						end else begin
							bit_n = bit_q + BIT_W'(1);
						end
					end else begin
						tick_n = tick_inc[TICK_W-1:0];
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sending_q <= 1'b0;
			mask_q    <= '0;
			bit_q     <= '0;
			tick_q    <= '0;
		end else if (adv) begin
			sending_q <= sending_n;
			mask_q    <= mask_n;
			bit_q     <= bit_n;
			tick_q    <= tick_n;
		end
	end

	for (genvar i = 0; i < LANES; i++) begin : g_lane
		always_comb begin
			ctl[i].wr       = adv && LANE_EXISTS[i] && opcode_t'(opcode_s1) == OP_WRITE
				&& channel_s1 == CH_W'(i);
			ctl[i].load     = adv && start && elig[i];
			ctl[i].in_frame = mask_n[i];
			ctl[i].bit_n    = bit_n;
			ctl[i].tick_n   = tick_n;
		end

		dsmt_lane u_lane (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl[i]),
			.throttle  (throttle_s1),
			.zero_high (zero_eff),
			.one_high  (one_high_q),
			.level     (levels[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pin_levels_q <= levels;
			busy_q       <= sending_n;
		end
	end

	assign res.valid      = res_valid_q;
	assign res.pin_levels = pin_levels_q;
	assign res.busy_res   = busy_q;

	a_idle_pins_low: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && !res.busy_res |-> res.pin_levels == '0)
		else $error("pins driven while no frame is in flight");

	a_idle_timer_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!sending_q |-> (bit_q == '0 && tick_q == '0 && mask_q == '0))
		else $error("timer or lane mask left over after a frame");

	// The bit period may be rewritten mid-frame, so only the lane mask is checked here.
	a_busy_has_lanes: assert property (@(posedge clk) disable iff (!arst_n)
		sending_q |-> mask_q != '0)
		else $error("frame in flight with no lanes");

	a_stall_holds_result: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && !res.ready |=> res_valid_q && $stable(pin_levels_q) && $stable(busy_q))
		else $error("result changed before its transfer");

endmodule
`default_nettype wire
